### hw/rtl/utf8_to_utf16_transcoder_top_assert.svh
// Assertion macros used by the checker file u2u_chk.sv.
`ifndef UTF8_TO_UTF16_TRANSCODER_TOP_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U2U_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define U2U_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/u2u_pkg.sv
`default_nettype none
package u2u_pkg;

	localparam int MAX_RESULTS = 4;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int IDX_W       = $clog2(MAX_RESULTS);

	localparam logic [20:0] REPL_CP      = 21'h00FFFD;
	localparam logic [20:0] MAX_CP       = 21'h10FFFF;
	localparam logic [20:0] SURR_FIRST   = 21'h00D800;
	localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
	localparam logic [20:0] HI_SURR_BASE = 21'h00D800;
	localparam logic [20:0] LO_SURR_BASE = 21'h00DC00;
	localparam logic [20:0] SUPP_BASE    = 21'h010000;
	localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
	localparam logic [20:0] MIN_TWO      = 21'h000080;
	localparam logic [20:0] MIN_THREE    = 21'h000800;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [20:0] code_unit;
		logic        replaced;
		logic        run_last;
		logic        string_end;
	} out_item_t;

	typedef struct packed {
		logic [20:0] code;
		logic        replaced;
	} unit_t;

	typedef struct packed {
		unit_t [MAX_RESULTS-1:0] units;
		logic [CNT_W-1:0]        count;
		logic                    last;
	} bundle_t;

endpackage
`default_nettype wire

### hw/rtl/u2u_decode.sv
`default_nettype none
module u2u_decode (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire u2u_pkg::in_item_t item,
	input  wire logic              take,
	input  wire logic              mode,
	output u2u_pkg::bundle_t       bundle
);

	logic [20:0] partial_q;
	logic [1:0]  needed_q;
	logic [1:0]  seen_q;

	logic [20:0] partial_d;
	logic [1:0]  needed_d;
	logic [1:0]  seen_d;

	always_comb begin
		logic [7:0]      b;
		logic            cont;
		logic [20:0]     cp;
		logic [1:0]      seen_n;
		logic [1:0]      needed_n;
		logic [20:0]     min_cp;
		logic [20:0]     supp;
		logic [2:0]      nflush;
		logic [1:0]      ntail;
		logic            do_lead;
		logic            bad;
		u2u_pkg::unit_t  t0;
		u2u_pkg::unit_t  t1;
		logic [1:0]      p0;
		logic [1:0]      p1;

		b        = item.in_byte;
		cont     = (b[7:6] == 2'b10);
		cp       = {partial_q[14:0], b[5:0]};
		seen_n   = seen_q + 2'd1;
		needed_n = needed_q - 2'd1;
		case (seen_n)
			2'd1:    min_cp = u2u_pkg::MIN_TWO;
			2'd2:    min_cp = u2u_pkg::MIN_THREE;
			default: min_cp = u2u_pkg::SUPP_BASE;
		endcase
		bad = (cp < min_cp) || (cp > u2u_pkg::MAX_CP) ||
			((cp >= u2u_pkg::SURR_FIRST) && (cp <= u2u_pkg::SURR_LAST));
		supp = cp - u2u_pkg::SUPP_BASE;

		partial_d = partial_q;
		needed_d  = needed_q;
		seen_d    = seen_q;
		nflush    = 3'd0;
		ntail     = 2'd0;
		do_lead   = 1'b0;
		t0        = '{code: u2u_pkg::REPL_CP, replaced: 1'b1};
		t1        = '{code: u2u_pkg::REPL_CP, replaced: 1'b1};

		if (needed_q != 2'd0) begin
			if (cont) begin
				partial_d = cp;
				seen_d    = seen_n;
				needed_d  = needed_n;
				if (needed_n == 2'd0) begin
					partial_d = '0;
					seen_d    = '0;
					if (bad) begin
						nflush = 3'd1 + {1'b0, seen_n};
					end else if (!mode && (cp > u2u_pkg::BMP_MAX)) begin
						ntail = 2'd2;
						t0 = '{code: u2u_pkg::HI_SURR_BASE + {11'd0, supp[19:10]},
							replaced: 1'b0};
						t1 = '{code: u2u_pkg::LO_SURR_BASE + {11'd0, supp[9:0]},
							replaced: 1'b0};
					end else begin
						ntail = 2'd1;
						t0 = '{code: cp, replaced: 1'b0};
					end
				end else if (item.in_last) begin
					nflush = 3'd1 + {1'b0, seen_n};
				end
			end else begin
				nflush   = 3'd1 + {1'b0, seen_q};
				do_lead  = 1'b1;
				partial_d = '0;
				needed_d  = '0;
				seen_d    = '0;
			end
		end else begin
			do_lead = 1'b1;
		end

		// Lead byte: ASCII passes, a valid lead opens a sequence, else FFFD.
		if (do_lead) begin
			if (!b[7]) begin
				ntail = 2'd1;
				t0 = '{code: {13'd0, b}, replaced: 1'b0};
			end else if ((b[7:5] == 3'b110) && !item.in_last) begin
				partial_d = {16'd0, b[4:0]};
				needed_d  = 2'd1;
				seen_d    = 2'd0;
			end else if ((b[7:4] == 4'b1110) && !item.in_last) begin
				partial_d = {17'd0, b[3:0]};
				needed_d  = 2'd2;
				seen_d    = 2'd0;
			end else if ((b[7:3] == 5'b11110) && !item.in_last) begin
				partial_d = {18'd0, b[2:0]};
				needed_d  = 2'd3;
				seen_d    = 2'd0;
			end else begin
				ntail = 2'd1;
			end
		end

		if (item.in_last) begin
			partial_d = '0;
			needed_d  = '0;
			seen_d    = '0;
		end

		// Pack flush replacements first, then the tail units.
		for (int i = 0; i < u2u_pkg::MAX_RESULTS; i++) begin
			bundle.units[i] = '{code: u2u_pkg::REPL_CP, replaced: 1'b1};
		end
		p0 = nflush[1:0];
		p1 = p0 + 2'd1;
		if (ntail != 2'd0) begin
			bundle.units[p0] = t0;
		end
		if (ntail == 2'd2) begin
			bundle.units[p1] = t1;
		end
		bundle.count = nflush + {1'b0, ntail};
		bundle.last  = item.in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			needed_q  <= '0;
			seen_q    <= '0;
		end else if (take) begin
			partial_q <= partial_d;
			needed_q  <= needed_d;
			seen_q    <= seen_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/u2u_drain.sv
`default_nettype none
module u2u_drain (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire u2u_pkg::bundle_t bundle,
	output logic                  free,
	output logic                  valid,
	input  wire logic             stall,
	output u2u_pkg::out_item_t    data
);

	u2u_pkg::bundle_t              bundle_s2;
	logic                          valid_s2;
	logic [u2u_pkg::IDX_W-1:0]     idx_q;
	logic                          is_last_unit;
	logic                          xfer;

	assign is_last_unit = ({1'b0, idx_q} == (bundle_s2.count - 1'b1));
	assign xfer         = valid_s2 && !stall;
	assign free         = !valid_s2 || (xfer && is_last_unit);

	assign valid           = valid_s2;
	assign data.code_unit  = bundle_s2.units[idx_q].code;
	assign data.replaced   = bundle_s2.units[idx_q].replaced;
	assign data.run_last   = is_last_unit;
	assign data.string_end = is_last_unit && bundle_s2.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (xfer) begin
			if (is_last_unit) begin
				valid_s2 <= 1'b0;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_s2 <= bundle;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/utf8_to_utf16_transcoder_top.sv
// UTF-8 to UTF-16/UTF-32 stream transcoder. Feed one UTF-8 byte per transfer
// with in_last set on the final byte of a string; results come out one code
// unit per transfer. cfg_data (written with cfg_we while idle) selects the
// format: 0 gives UTF-16 code units with surrogate pairs, 1 whole code points.
// Bad input is replaced by U+FFFD (replaced = 1): one for the lead byte of a
// broken sequence and one for every continuation byte already taken. run_last
// marks the final result of each input byte, string_end the final result of a
// byte that carried in_last. Rate: one input byte per cycle whenever a byte
// gives zero or one result and the output is not stalled; a byte giving more
// than one result holds the input until the output drains them, one unit per
// cycle while not stalled, from the result register. A byte passes through
// the input register, then the result register, before its first result.
`default_nettype none
module utf8_to_utf16_transcoder_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire u2u_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output u2u_pkg::out_item_t     out_data,
	input  wire logic              cfg_we,
	input  wire logic              cfg_data
);

	logic              mode_q;
	logic              valid_s1;
	u2u_pkg::in_item_t item_s1;
	u2u_pkg::bundle_t  bundle;
	logic              free;
	logic              adv_s1;
	logic              in_xfer;

	// Advance the input register when the result register can take the
	// bundle, or drop it at once when the byte gives no result.
	assign adv_s1   = valid_s1 && (free || (bundle.count == '0));
	assign in_stall = valid_s1 && !adv_s1;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the payload while stalled.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_data;
		end
	end

	// Decode the byte against the open sequence; commit state on advance.
	u2u_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.take   (adv_s1),
		.mode   (mode_q),
		.bundle (bundle)
	);

	// Drain the result bundle one code unit per output transfer.
	u2u_drain u_drain (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv_s1 && (bundle.count != '0)),
		.bundle (bundle),
		.free   (free),
		.valid  (out_valid),
		.stall  (out_stall),
		.data   (out_data)
	);

endmodule
`default_nettype wire

### hw/rtl/u2u_chk.sv
`default_nettype none
`include "utf8_to_utf16_transcoder_top_assert.svh"
module u2u_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire u2u_pkg::out_item_t out_data
);

	`U2U_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`U2U_ASSERT_IMPL(a_end_is_last, clk, arst_n, out_valid && out_data.string_end, out_data.run_last)
	`U2U_ASSERT_IMPL(a_repl_code, clk, arst_n, out_valid && out_data.replaced, out_data.code_unit == u2u_pkg::REPL_CP)
	`U2U_ASSERT_IMPL(a_code_range, clk, arst_n, out_valid, out_data.code_unit <= u2u_pkg::MAX_CP)

endmodule

bind utf8_to_utf16_transcoder_top u2u_chk u_chk (.*);
`default_nettype wire
